/* src/ssq_pkg.sv */
`default_nettype none
package ssq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 16;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = PTR_W + 1;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_TOGGLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic MODE_STACK = 1'b0;
  localparam logic MODE_QUEUE = 1'b1;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data_out;
    status_t               status;
    logic                  mode_now;
    logic [CNT_W-1:0]      fill_count;
  } result_t;

endpackage
`default_nettype wire

/* src/switchable_stack_queue_core.sv */
// Results: a result is registered into res from its accepted word, or into skid while res is stalled.
// Throughput: one word per cycle while item_stall is low; the state update has no loop, and a
// two-entry result buffer lets one more word in while a result is stalled.
// Reset (rst, synchronous): front pointer, count and mode (stack) cleared,
// result buffer emptied. The word store is not cleared.
`default_nettype none
module switchable_stack_queue_core
  import ssq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output      logic                  item_stall,
  input  wire logic [1:0]            operation,
  input  wire logic [DATA_WIDTH-1:0] value,
  output      logic                  result_valid,
  input  wire logic                  result_stall,
  output      logic [DATA_WIDTH-1:0] data_out,
  output      logic [1:0]            status,
  output      logic                  mode_now,
  output      logic [CNT_W-1:0]      fill_count
);

  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0]      front;
  logic [CNT_W-1:0]      occ;
  logic                  mode;

  logic [PTR_W-1:0]      front_next;
  logic [CNT_W-1:0]      occ_next;
  logic                  mode_next;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_idx;
  result_t               res_next;

  result_t               res;
  result_t               skid;
  logic                  skid_valid;

  logic                  acc;
  logic                  take;
  logic                  is_full;
  logic                  is_empty;
  logic [PTR_W-1:0]      front_dec;
  logic [PTR_W-1:0]      front_inc;
  logic [SUM_W-1:0]      back_sum;
  logic [SUM_W-1:0]      back_wrap;

  assign item_stall = skid_valid;
  assign acc        = item_valid && !skid_valid;
  assign take       = result_valid && !result_stall;

  assign is_full   = (occ == CNT_W'(DEPTH));
  assign is_empty  = (occ == '0);
  assign front_dec = (front == '0) ? PTR_W'(DEPTH - 1) : front - PTR_W'(1);
  assign front_inc = (front == PTR_W'(DEPTH - 1)) ? '0 : front + PTR_W'(1);
  assign back_sum  = {1'b0, front} + SUM_W'(occ);
  assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;

  always_comb begin
    front_next = front;
    occ_next   = occ;
    mode_next  = mode;
    wr_en      = 1'b0;
    wr_idx     = front_dec;
    res_next.data_out = '0;
    res_next.status   = ST_OK;
    case (op_t'(operation))
      OP_PUSH: begin
        if (is_full) begin
          res_next.status = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          occ_next = occ + CNT_W'(1);
          if (mode == MODE_STACK) begin
            wr_idx     = front_dec;
            front_next = front_dec;
          end else begin
            wr_idx = back_wrap[PTR_W-1:0];
          end
        end
      end
      OP_POP: begin
        if (is_empty) begin
          res_next.status = ST_EMPTY;
        end else begin
          res_next.data_out = entries[front];
          front_next        = front_inc;
          occ_next          = occ - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (is_empty) begin
          res_next.status = ST_EMPTY;
        end else begin
          res_next.data_out = entries[front];
        end
      end
      OP_TOGGLE: begin
        mode_next = ~mode;
      end
      default: begin
        mode_next = mode;
      end
    endcase
    res_next.mode_now   = mode_next;
    res_next.fill_count = occ_next;
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      entries[wr_idx] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      occ   <= '0;
      mode  <= MODE_STACK;
    end else if (acc) begin
      front <= front_next;
      occ   <= occ_next;
      mode  <= mode_next;
    end
  end

  // two-entry result buffer: res is the visible word, skid holds one behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take || !result_valid) begin
      if (skid_valid) begin
        res          <= skid;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        if (acc) begin
          res <= res_next;
        end
        result_valid <= acc;
      end
    end else if (acc) begin
      skid       <= res_next;
      skid_valid <= 1'b1;
    end
  end

  assign data_out   = res.data_out;
  assign status     = res.status;
  assign mode_now   = res.mode_now;
  assign fill_count = res.fill_count;

  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid word held with no visible result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (fill_count <= CNT_W'(DEPTH)))
    else $error("fill count beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_FULL) |-> (fill_count == CNT_W'(DEPTH) && data_out == '0))
    else $error("full status with buffer not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_EMPTY) |-> (fill_count == '0 && data_out == '0))
    else $error("empty status with words stored");

endmodule
`default_nettype wire

/* tb/tb_switchable_stack_queue_core.sv */
`timescale 1ns / 100ps
module tb_switchable_stack_queue_core;
  import ssq_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_WORDS = 810;
  localparam int REPORT_CAP = 30;

  typedef struct {
    op_t                   op;
    logic [DATA_WIDTH-1:0] val;
  } in_word_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [1:0]            operation = OP_PEEK;
  logic [DATA_WIDTH-1:0] value = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [DATA_WIDTH-1:0] data_out;
  logic [1:0]            status;
  logic                  mode_now;
  logic [CNT_W-1:0]      fill_count;

  switchable_stack_queue_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .value(value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .data_out(data_out),
    .status(status),
    .mode_now(mode_now),
    .fill_count(fill_count)
  );

  in_word_t words_to_send[$];
  result_t  replies_due[$];
  int       errors = 0;
  int       quiet = 0;
  bit       word_sent = 1'b0;
  int       send_gap = 0;
  int       send_calm = 0;
  int       hold_left = 0;
  int       hold_calm = 0;

  // predictor state: circular store, front pointer, count, mode
  logic [DATA_WIDTH-1:0] slots[DEPTH];
  logic [PTR_W-1:0]      head = '0;
  logic [CNT_W-1:0]      held = '0;
  logic                  order_mode = MODE_STACK;

  task automatic compute_reply(input op_t op, input logic [DATA_WIDTH-1:0] w,
                               output result_t r);
    logic [PTR_W-1:0] tail;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held == CNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else if (order_mode == MODE_STACK) begin
          head = head - PTR_W'(1);
          slots[head] = w;
          held = held + CNT_W'(1);
        end else begin
          tail = head + held[PTR_W-1:0];
          slots[tail] = w;
          held = held + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (held == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = slots[head];
          head = head + PTR_W'(1);
          held = held - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (held == '0) r.status = ST_EMPTY;
        else r.data_out = slots[head];
      end
      default: order_mode = ~order_mode;
    endcase
    r.mode_now = order_mode;
    r.fill_count = held;
  endtask

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 15) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 650) return 0;
    if (r < 930) return $urandom_range(1, 3);
    if (r < 985) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] draw_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DATA_WIDTH'($urandom);
  endfunction

  task automatic add_word(input op_t op, input logic [DATA_WIDTH-1:0] v);
    in_word_t w;
    w.op = op;
    w.val = v;
    words_to_send.push_back(w);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    errors++;
    if (errors <= REPORT_CAP) $error("%s: expected %0h, got %0h", name, want, got);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // word driver
  always @(negedge clk) begin : drive_words
    in_word_t nxt;
    if (!rst && (!item_valid || word_sent)) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        nxt = words_to_send.pop_front();
        item_valid <= 1'b1;
        operation <= nxt.op;
        value <= nxt.val;
        send_gap = draw_gap(send_calm);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left == 0) hold_left = draw_gap(hold_calm);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // monitor: results checked before the new word is predicted
  always @(posedge clk) begin : watch_ports
    result_t want;
    result_t fresh;
    bit      got_result;
    word_sent = 1'b0;
    got_result = 1'b0;
    if (!rst) begin
      if (result_valid === 1'b1 && result_stall == 1'b0) begin
        got_result = 1'b1;
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP) $error("result word with none outstanding");
        end else begin
          want = replies_due.pop_front();
          if (data_out !== want.data_out) report_field("data_out", want.data_out, data_out);
          if (status !== want.status) report_field("status", want.status, status);
          if (mode_now !== want.mode_now) report_field("mode_now", want.mode_now, mode_now);
          if (fill_count !== want.fill_count)
            report_field("fill_count", want.fill_count, fill_count);
        end
      end
      if (item_valid && item_stall === 1'b0) begin
        word_sent = 1'b1;
        compute_reply(op_t'(operation), value, fresh);
        replies_due.push_back(fresh);
      end
      if (word_sent || got_result) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    int burst;
    int push_pct;
    int pop_pct;
    int r;
    op_t op;

    // empty-buffer reads, extreme words, full buffer with a dropped push
    add_word(OP_POP, 16'h1234);
    add_word(OP_PEEK, 16'hFFFF);
    add_word(OP_PUSH, 16'hFFFF);
    add_word(OP_PUSH, 16'h0000);
    add_word(OP_PEEK, 16'h0000);
    add_word(OP_POP, 16'hFFFF);
    add_word(OP_TOGGLE, 16'hA5A5);
    for (int i = 0; i < DEPTH - 1; i++) add_word(OP_PUSH, draw_value());
    add_word(OP_PUSH, 16'h5555);
    add_word(OP_TOGGLE, 16'h0000);
    add_word(OP_POP, 16'hAAAA);

    // random bursts, biased to swing between full and empty
    n = 0;
    while (n < RANDOM_WORDS) begin
      burst = $urandom_range(15, 60);
      r = $urandom_range(0, 2);
      push_pct = (r == 0) ? 65 : (r == 1) ? 20 : 40;
      pop_pct = (r == 0) ? 20 : (r == 1) ? 65 : 40;
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) op = OP_PUSH;
        else if (r < push_pct + pop_pct) op = OP_POP;
        else if (r < 95) op = OP_PEEK;
        else op = OP_TOGGLE;
        add_word(op, draw_value());
      end
      n += burst;
    end

    @(negedge clk);
    while (rst || words_to_send.size() != 0 || item_valid || replies_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
